// File: hdl/wat_pkg.sv
// Shared constants and types for the weighted average track mixer.
// This package stands alone and is used by every module under hdl.
package wat_pkg;

    // Fixed field widths of the sample stream and the weight registers.
    localparam int SAMPLE_W     = 16;
    localparam int WEIGHT_W     = 12;
    localparam int MASK_W       = 4;
    localparam int MAX_TRACKS   = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int TRACKS_DEFAULT = 4;

    // One weighted product: signed sample times unsigned Q4.8 weight.
    localparam int PROD_W       = SAMPLE_W + WEIGHT_W;

    // Quotient magnitude never exceeds the most negative sample magnitude.
    localparam int QUO_W        = SAMPLE_W;
    localparam logic [QUO_W-1:0] QUO_MAX = QUO_W'(32768);

    // Reset weight is 1.0 in Q4.8.
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(256);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [WEIGHT_W-1:0] t_weight;

endpackage

// File: hdl/wat_mac.sv
// Two-stage weighted multiply-accumulate: per-track products, then their sum.
// Depends on wat_pkg for field widths and types.
module wat_mac
    import wat_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEFAULT,
    parameter int ACC_W  = PROD_W + $clog2(TRACKS),
    parameter int WSUM_W = WEIGHT_W + $clog2(TRACKS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_sample                  i_sample [MAX_TRACKS],
    input  logic [MASK_W-1:0]        i_mask,
    input  t_weight                  i_weight [TRACKS],
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [ACC_W-1:0]  o_acc,
    output logic [WSUM_W-1:0]        o_wsum
);

    logic                     r_v1;
    logic                     r_v2;
    logic                     w_rdy1;
    logic                     w_rdy2;
    logic signed [PROD_W-1:0] r_prod [TRACKS];
    logic signed [PROD_W-1:0] n_prod [TRACKS];
    logic [WSUM_W-1:0]        r_wsum1;
    logic [WSUM_W-1:0]        n_wsum1;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic [WSUM_W-1:0]        r_wsum2;

    // A stage takes a new transaction when it is empty or its successor moves.
    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage one: gated products and the sum of active weights.
    always_comb begin
        logic signed [PROD_W:0] full;
        n_wsum1 = '0;
        for (int k = 0; k < TRACKS; k++) begin
            full = i_sample[k] * $signed({1'b0, i_weight[k]});
            if (i_mask[k]) begin
                n_prod[k] = full[PROD_W-1:0];
                n_wsum1   = n_wsum1 + WSUM_W'(i_weight[k]);
            end else begin
                n_prod[k] = '0;
            end
        end
    end

    // Stage two: exact sum of the products.
    always_comb begin
        n_acc = '0;
        for (int k = 0; k < TRACKS; k++) begin
            n_acc = n_acc + ACC_W'(r_prod[k]);
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_prod  <= n_prod;
            r_wsum1 <= n_wsum1;
        end
        if (w_rdy2 && r_v1) begin
            r_acc   <= n_acc;
            r_wsum2 <= r_wsum1;
        end
    end

    assign o_valid = r_v2;
    assign o_acc   = r_acc;
    assign o_wsum  = r_wsum2;

endmodule

// File: hdl/wat_div.sv
// Pipelined signed divider: magnitude stage, one quotient bit per stage,
// then sign restore and the output register. Depends on wat_pkg.
module wat_div
    import wat_pkg::*;
#(
    parameter int ACC_W  = PROD_W + 2,
    parameter int WSUM_W = WEIGHT_W + 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [ACC_W-1:0]  i_acc,
    input  logic [WSUM_W-1:0]        i_wsum,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_sample                  o_mixed_sample,
    output logic                     o_none_active
);

    localparam int MAG_W = ACC_W - 1;
    localparam int CMP_W = WSUM_W + QUO_W;
    localparam int NSTG  = QUO_W + 1;

    // Stage 0 holds the magnitude; stage j holds j quotient bits.
    logic              r_v    [NSTG];
    logic [MAG_W-1:0]  r_rem  [NSTG];
    logic [WSUM_W-1:0] r_dvs  [NSTG];
    logic [QUO_W-1:0]  r_quo  [NSTG];
    logic              r_neg  [NSTG];
    logic              r_zero [NSTG];
    logic              w_rdy  [NSTG+1];

    logic              r_ov;
    t_sample           r_out;
    logic              r_none;
    t_sample           n_out;
    logic [ACC_W-1:0]  n_mag;
    logic [QUO_W-1:0]  w_quo_neg;

    // Ready chain; the last entry belongs to the output register.
    assign w_rdy[NSTG] = !r_ov || i_ready;
    generate
        for (genvar j = 0; j < NSTG; j++) begin : g_rdy
            assign w_rdy[j] = !r_v[j] || w_rdy[j+1];
        end
    endgenerate
    assign o_ready = w_rdy[0];

    // Magnitude stage: split the sign off the accumulated sum.
    assign n_mag = i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_rem[0]  <= n_mag[MAG_W-1:0];
            r_dvs[0]  <= i_wsum;
            r_quo[0]  <= '0;
            r_neg[0]  <= i_acc[ACC_W-1];
            r_zero[0] <= (i_wsum == '0);
        end
    end

    // Restoring steps: each stage settles one quotient bit, MSB first.
    generate
        for (genvar j = 1; j < NSTG; j++) begin : g_step
            localparam int SH = QUO_W - j;
            logic [CMP_W-1:0] w_sh;
            logic [CMP_W-1:0] w_diff;
            logic             w_ge;
            logic [MAG_W-1:0] n_rem;
            logic [QUO_W-1:0] n_quo;

            assign w_sh   = CMP_W'(r_dvs[j-1]) << SH;
            assign w_ge   = CMP_W'(r_rem[j-1]) >= w_sh;
            assign w_diff = CMP_W'(r_rem[j-1]) - w_sh;
            assign n_rem  = w_ge ? w_diff[MAG_W-1:0] : r_rem[j-1];

            always_comb begin
                n_quo     = r_quo[j-1];
                n_quo[SH] = w_ge;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (w_rdy[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[j] && r_v[j-1]) begin
                    r_rem[j]  <= n_rem;
                    r_dvs[j]  <= r_dvs[j-1];
                    r_quo[j]  <= n_quo;
                    r_neg[j]  <= r_neg[j-1];
                    r_zero[j] <= r_zero[j-1];
                end
            end
        end
    endgenerate

    // Output stage: restore the sign, force zero when no weight is active.
    assign w_quo_neg = -r_quo[QUO_W];

    always_comb begin
        if (r_zero[QUO_W]) begin
            n_out = '0;
        end else if (r_neg[QUO_W]) begin
            n_out = w_quo_neg;
        end else begin
            n_out = r_quo[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rdy[NSTG]) begin
            r_ov <= r_v[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NSTG] && r_v[QUO_W]) begin
            r_out  <= n_out;
            r_none <= r_zero[QUO_W];
        end
    end

    assign o_valid        = r_ov;
    assign o_mixed_sample = r_out;
    assign o_none_active  = r_none;

    // A finished division leaves a remainder below the divisor.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QUO_W] && !r_zero[QUO_W] |-> CMP_W'(r_rem[QUO_W]) < CMP_W'(r_dvs[QUO_W]))
        else $error("division remainder not below divisor");

    // The quotient magnitude stays within the sample range.
    a_quo_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QUO_W] && !r_zero[QUO_W] |-> r_quo[QUO_W] <= QUO_MAX)
        else $error("quotient magnitude out of sample range");

    // A result flagged as having no active weight carries a zero sample.
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_none |-> r_out == '0)
        else $error("none_active result with nonzero sample");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_ov)
        else $error("output valid after reset");

endmodule

// File: hdl/weighted_average_track_mixer.sv
// Twenty register stages: two multiply-accumulate stages, one magnitude stage, sixteen
// quotient-bit stages of the divider and one output register; the accepting edge loads
// the first. Throughput: one transaction per cycle while i_ready does not stall the
// output; the 16-stage restoring divider pipeline sets the depth.
// Reset (synchronous, active low) empties every stage and sets all weights
// to 1.0 (256 in Q4.8). Depends on wat_pkg, wat_mac and wat_div.
module weighted_average_track_mixer
    import wat_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Sample set channel.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_sample              i_sample_0,
    input  t_sample              i_sample_1,
    input  t_sample              i_sample_2,
    input  t_sample              i_sample_3,
    input  logic [MASK_W-1:0]    i_active_mask,
    // Mixed sample channel.
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_sample              o_mixed_sample,
    output logic                 o_none_active,
    // Weight register write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_weight              i_cfg_data
);

    localparam int ACC_W  = PROD_W + $clog2(TRACKS);
    localparam int WSUM_W = WEIGHT_W + $clog2(TRACKS);

    t_weight                 r_weight [TRACKS];
    t_sample                 w_sample [MAX_TRACKS];
    logic                    w_mac_valid;
    logic                    w_mac_ready;
    logic signed [ACC_W-1:0] w_acc;
    logic [WSUM_W-1:0]       w_wsum;

    // Weight registers; writes to an index without a track are dropped.
    assign o_cfg_ready = 1'b1;

    generate
        for (genvar k = 0; k < TRACKS; k++) begin : g_weight
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_weight[k] <= WEIGHT_RESET;
                end else if (i_cfg_valid && i_cfg_index == CFG_IDX_W'(k)) begin
                    r_weight[k] <= i_cfg_data;
                end
            end
        end
    endgenerate

    // Gather the sample ports into one array.
    assign w_sample[0] = i_sample_0;
    assign w_sample[1] = i_sample_1;
    assign w_sample[2] = i_sample_2;
    assign w_sample[3] = i_sample_3;

    // Weighted products and their sum.
    wat_mac #(
        .TRACKS (TRACKS),
        .ACC_W  (ACC_W),
        .WSUM_W (WSUM_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (w_sample),
        .i_mask   (i_active_mask),
        .i_weight (r_weight),
        .o_valid  (w_mac_valid),
        .i_ready  (w_mac_ready),
        .o_acc    (w_acc),
        .o_wsum   (w_wsum)
    );

    // Division by the active weight sum.
    wat_div #(
        .ACC_W  (ACC_W),
        .WSUM_W (WSUM_W)
    ) u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_mac_valid),
        .o_ready        (w_mac_ready),
        .i_acc          (w_acc),
        .i_wsum         (w_wsum),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mixed_sample (o_mixed_sample),
        .o_none_active  (o_none_active)
    );

endmodule

// File: dv/weighted_average_track_mixer_test.sv
// Self-checking testbench for weighted_average_track_mixer: directed and random sample
// sets under several weight settings and idle patterns, checked against a local predictor.
// Depends on wat_pkg and the mixer RTL under hdl.
module weighted_average_track_mixer_test;
    import wat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRACKS          = TRACKS_DEFAULT;
    localparam int PIPE_LATENCY    = 20;
    localparam int IDLE_LIMIT      = 4000;
    localparam int REPORT_LIMIT    = 10;
    localparam int RANDOM_PHASES   = 8;
    localparam int SETS_PER_PHASE  = 185;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_0,
        REG_WEIGHT_1,
        REG_WEIGHT_2,
        REG_WEIGHT_3
    } weight_reg_e;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    typedef struct packed {
        t_sample [MAX_TRACKS-1:0] samples;
        logic    [MASK_W-1:0]     mask;
    } sample_set_t;

    typedef struct packed {
        t_sample mixed;
        logic    none;
    } mix_result_t;

    // Block ports; the inputs are at known values from time zero.
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    t_sample           i_sample_0    = '0;
    t_sample           i_sample_1    = '0;
    t_sample           i_sample_2    = '0;
    t_sample           i_sample_3    = '0;
    logic [MASK_W-1:0] i_active_mask = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    t_sample           o_mixed_sample;
    logic              o_none_active;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    weight_reg_e       i_cfg_index   = REG_WEIGHT_0;
    t_weight           i_cfg_data    = '0;

    // Shadow copy of the weight registers, updated when a write transaction lands.
    t_weight [MAX_TRACKS-1:0] track_weight = {MAX_TRACKS{WEIGHT_RESET}};

    sample_set_t pending_sets [$];
    mix_result_t expected_mix [$];
    sample_set_t cur_set;

    int sets_queued    = 0;
    int sets_accepted  = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int weight_configs = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;

    weighted_average_track_mixer #(
        .TRACKS(TRACKS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_0    (i_sample_0),
        .i_sample_1    (i_sample_1),
        .i_sample_2    (i_sample_2),
        .i_sample_3    (i_sample_3),
        .i_active_mask (i_active_mask),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_mixed_sample(o_mixed_sample),
        .o_none_active (o_none_active),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Weighted average of the active tracks; the quotient truncates toward zero.
    function automatic mix_result_t mix_predict(input sample_set_t set);
        longint      acc;
        longint      wsum;
        longint      quo;
        mix_result_t res;
        int          k;
        acc  = 0;
        wsum = 0;
        for (k = 0; k < TRACKS; k++) begin
            if (set.mask[k]) begin
                acc  += longint'($signed(set.samples[k])) * longint'(track_weight[k]);
                wsum += longint'(track_weight[k]);
            end
        end
        if (wsum == 0) begin
            res.mixed = '0;
            res.none  = 1'b1;
        end else begin
            quo = acc / wsum;
            if (quo > 32767)
                quo = 32767;
            if (quo < -32768)
                quo = -32768;
            res.mixed = t_sample'(quo);
            res.none  = 1'b0;
        end
        return res;
    endfunction

    function automatic sample_set_t make_set(input int mask, input int s0, input int s1,
                                             input int s2, input int s3);
        sample_set_t set;
        set.mask       = MASK_W'(mask);
        set.samples[0] = t_sample'(s0);
        set.samples[1] = t_sample'(s1);
        set.samples[2] = t_sample'(s2);
        set.samples[3] = t_sample'(s3);
        return set;
    endfunction

    // Random sample set biased toward full-scale and near-zero samples.
    function automatic sample_set_t random_set();
        sample_set_t set;
        int          k;
        set.mask = MASK_W'($urandom_range(15));
        for (k = 0; k < MAX_TRACKS; k++) begin
            case ($urandom_range(9))
                0: set.samples[k] = t_sample'(-32768);
                1: set.samples[k] = t_sample'(32767);
                2: set.samples[k] = t_sample'(int'($urandom_range(15)) - 8);
                default: set.samples[k] = t_sample'($urandom);
            endcase
        end
        return set;
    endfunction

    // Weight setting of one random phase; hot picks the single live track where needed.
    function automatic t_weight phase_weight(input int ph, input int k, input int hot);
        case (ph)
            0: return t_weight'(4095);
            2: return (k == hot) ? t_weight'($urandom) : t_weight'(0);
            3: return t_weight'($urandom_range(3));
            4: return t_weight'(0);
            5: begin
                case (k)
                    0: return t_weight'(1);
                    1: return t_weight'(4095);
                    2: return t_weight'($urandom);
                    default: return t_weight'(0);
                endcase
            end
            7: return t_weight'($urandom_range(15));
            default: return t_weight'($urandom);
        endcase
    endfunction

    task automatic queue_set(input sample_set_t set);
        pending_sets.push_back(set);
        sets_queued++;
    endtask

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 82;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 82;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 20;
                recv_stall_pct = 20;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // One write transaction per weight register; only called while the block is idle.
    task automatic write_weights(input t_weight [MAX_TRACKS-1:0] w);
        weight_reg_e idx;
        int          k;
        idx = REG_WEIGHT_0;
        for (k = 0; k < MAX_TRACKS; k++) begin
            @(posedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= w[k];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            track_weight[idx] = w[k];
            i_cfg_valid <= 1'b0;
            idx = idx.next();
        end
        weight_configs++;
    endtask

    task automatic wait_drained();
        while (results_seen < sets_queued)
            @(posedge i_clk);
    endtask

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sample set driver: records an expectation per accepted transaction, then loads the next.
    always @(posedge i_clk) begin : sample_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_mix.push_back(mix_predict(cur_set));
                sets_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (pending_sets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_set = pending_sets.pop_front();
                    i_sample_0    <= cur_set.samples[0];
                    i_sample_1    <= cur_set.samples[1];
                    i_sample_2    <= cur_set.samples[2];
                    i_sample_3    <= cur_set.samples[3];
                    i_active_mask <= cur_set.mask;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Mixed sample monitor: compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin : mix_monitor
        mix_result_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_mix.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("Unexpected result: mixed %0d none_active %0b",
                                 o_mixed_sample, o_none_active);
                end else begin
                    want = expected_mix.pop_front();
                    if (o_mixed_sample !== want.mixed || o_none_active !== want.none) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("Mismatch: expected mixed %0d none_active %0b, got %0d %0b",
                                     want.mixed, want.none, o_mixed_sample, o_none_active);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transaction on any channel.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a transaction", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        t_weight [MAX_TRACKS-1:0] w;
        int                       ph;
        int                       k;
        int                       hot;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sets under the reset weights of 1.0 per track.
        set_idle(IDLE_NONE);
        queue_set(make_set(0, 32767, -32768, 32767, -32768));   // nothing active
        queue_set(make_set(15, 32767, 32767, 32767, 32767));
        queue_set(make_set(15, -32768, -32768, -32768, -32768));
        queue_set(make_set(1, -32768, 32767, 32767, 32767));
        queue_set(make_set(8, -32768, -32768, -32768, 32767));
        queue_set(make_set(15, 32767, -32768, 32767, -32768));  // -0.5 truncates to 0
        queue_set(make_set(3, -1, 0, 32767, 32767));
        queue_set(make_set(7, -5, 0, 0, -32768));                // -5/3 truncates to -1
        queue_set(make_set(5, 7, -32768, 0, 32767));
        queue_set(make_set(10, 32767, 0, -32768, -7));
        queue_set(make_set(6, 1234, -4321, 999, 32767));
        wait_drained();

        // Directed sets with zero and full-scale weights, including a zero weight sum.
        w = {t_weight'(1), t_weight'(4095), t_weight'(0), t_weight'(0)};
        write_weights(w);
        queue_set(make_set(3, 32767, -32768, 5, 5));             // weight sum is zero
        queue_set(make_set(1, 32767, 0, 0, 0));
        queue_set(make_set(4, 0, 0, -32768, 0));
        queue_set(make_set(12, 0, 0, 32767, -32768));
        queue_set(make_set(15, -32768, -32768, -32768, -32768));
        queue_set(make_set(8, 0, 0, 0, 32767));
        queue_set(make_set(0, 1, 2, 3, 4));
        queue_set(make_set(15, 32767, 32767, -1, 1));
        wait_drained();

        // Random phases, each with its own weight setting and idle pattern.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            hot = $urandom_range(MAX_TRACKS - 1);
            for (k = 0; k < MAX_TRACKS; k++)
                w[k] = phase_weight(ph, k, hot);
            write_weights(w);
            set_idle(idle_mode_e'(ph % 4));
            repeat (SETS_PER_PHASE) queue_set(random_set());
            wait_drained();
        end

        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        if (expected_mix.size() != 0) begin
            $display("%0d expected results never arrived", expected_mix.size());
            fail_count += expected_mix.size();
        end

        $display("Mixed %0d sample sets under %0d weight settings and four idle patterns.",
                 sets_accepted, weight_configs + 1);
        $display("Checked %0d results, %0d failures.", results_seen, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
